// ===== design/packed_genotype_stream_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Packed genotype stream decoder - assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PACKED_GENOTYPE_STREAM_DECODER_MACROS_SVH
`define PACKED_GENOTYPE_STREAM_DECODER_MACROS_SVH

// Same-cycle implication.
`define PGSD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PGSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pgsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed genotype stream decoder package
// Payload types, queue entry type, register indexes and the pair decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgsd_pkg;

   localparam logic [1:0]  HEADER_LEN  = 2'd3;
   localparam logic [1:0]  LAST_PAIR   = 2'd3;
   localparam logic [23:0] ROW_MAX     = 24'hFF_FFFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 25;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_payload_type;

   typedef struct packed {
      logic [23:0] row_index;
      logic [19:0] sample_index;
      logic [1:0]  genotype;
      logic        out_of_range;
      logic        last;
   } rsp_payload_type;

   typedef enum logic {
      ENTRY_CLEAR,
      ENTRY_DATA
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type kind;
      logic [7:0]     data_byte;
   } queue_entry_type;

   // 0 and missing -> 0, 2 -> 1, 3 -> 2
   function automatic logic [1:0] decode_pair(input logic [1:0] code);
      logic [1:0] result;
      begin
         case (code)
            2'd2: result = 2'd1;
            2'd3: result = 2'd2;
            default: result = 2'd0;
         endcase
         return result;
      end
   endfunction

endpackage

// ===== design/pgsd_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Accepts raw bytes, strips the file header and queues clear/data entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgsd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  pgsd_pkg::req_payload_type req_payload,
   input  logic                    queue_full,
   output logic                    push,
   output pgsd_pkg::queue_entry_type push_entry
);
   import pgsd_pkg::*;

   logic [1:0] header_seen_ff;
   logic [1:0] header_seen_in;
   logic       accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      header_seen_in       = header_seen_ff;
      push                 = 1'b0;
      push_entry.kind      = ENTRY_DATA;
      push_entry.data_byte = req_payload.data_byte;
      if (accept) begin
         if (req_payload.start_of_file) begin
            // first header byte of a new file; counters clear in the back end
            header_seen_in  = 2'd1;
            push            = 1'b1;
            push_entry.kind = ENTRY_CLEAR;
         end else if (header_seen_ff < HEADER_LEN) begin
            header_seen_in = header_seen_ff + 2'd1;
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_seen_ff <= 2'd0;
      end else begin
         header_seen_ff <= header_seen_in;
      end
   end

endmodule

// ===== design/pgsd_queue.sv =====
// ----------------------------------------------------------------------------
// Entry queue
// Small FIFO between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgsd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pgsd_pkg::queue_entry_type push_entry,
   input  logic                      pop,
   output pgsd_pkg::queue_entry_type head_entry,
   output logic                      head_valid,
   output logic                      full
);
   import pgsd_pkg::*;

   queue_entry_type        entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   assign head_entry = entries_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/pgsd_back.sv =====
// ----------------------------------------------------------------------------
// Back end
// Splits data bytes into genotype results, one per cycle while the output is
// not stalled, and tracks the sample and row counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgsd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  pgsd_pkg::queue_entry_type head_entry,
   input  logic                      head_valid,
   output logic                      pop,
   input  logic [20:0]               sample_count,
   input  logic [24:0]               row_count,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pgsd_pkg::rsp_payload_type rsp_payload
);
   import pgsd_pkg::*;

   logic [1:0]      pair_ff;
   logic [1:0]      pair_in;
   logic [19:0]     sample_counter_ff;
   logic [19:0]     sample_counter_in;
   logic [23:0]     row_counter_ff;
   logic [23:0]     row_counter_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;

   logic        out_free;
   logic        issue;
   logic        clear;
   logic [20:0] next_sample;
   logic        row_done;
   logic        byte_done;
   logic [1:0]  code;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign clear       = head_valid && (head_entry.kind == ENTRY_CLEAR);
   assign issue       = head_valid && (head_entry.kind == ENTRY_DATA) && out_free;
   assign next_sample = {1'b0, sample_counter_ff} + 21'd1;
   // a zero sample count ends every row after one sample; bit 20 caps the row
   assign row_done    = (next_sample >= sample_count) || next_sample[20];
   assign byte_done   = row_done || (pair_ff == LAST_PAIR);
   assign code        = head_entry.data_byte[{pair_ff, 1'b0} +: 2];
   assign pop         = clear || (issue && byte_done);

   always_comb begin
      pair_in           = pair_ff;
      sample_counter_in = sample_counter_ff;
      row_counter_in    = row_counter_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_payload_in    = rsp_payload_ff;
      if (clear) begin
         pair_in           = 2'd0;
         sample_counter_in = '0;
         row_counter_in    = '0;
      end else if (issue) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.row_index    = row_counter_ff;
         rsp_payload_in.sample_index = sample_counter_ff;
         rsp_payload_in.genotype     = decode_pair(code);
         rsp_payload_in.out_of_range = ({1'b0, row_counter_ff} >= row_count);
         rsp_payload_in.last         = byte_done;
         pair_in                     = byte_done ? 2'd0 : pair_ff + 2'd1;
         if (row_done) begin
            sample_counter_in = '0;
            if (row_counter_ff != ROW_MAX) begin
               row_counter_in = row_counter_ff + 24'd1;
            end
         end else begin
            sample_counter_in = next_sample[19:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff           <= 2'd0;
         sample_counter_ff <= '0;
         row_counter_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pair_ff           <= pair_in;
         sample_counter_ff <= sample_counter_in;
         row_counter_ff    <= row_counter_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`include "packed_genotype_stream_decoder_macros.svh"

   `PGSD_ASSERT_SAME(a_pop_has_head, pop, head_valid, "pop from empty queue")
   `PGSD_ASSERT_SAME(a_mid_byte_is_data, pair_ff != 2'd0,
      head_valid && (head_entry.kind == ENTRY_DATA), "pair index set without data byte")
   `PGSD_ASSERT_NEXT(a_clear_zeroes, clear,
      (sample_counter_ff == '0) && (row_counter_ff == '0) && (pair_ff == 2'd0),
      "counters not cleared at start of file")

endmodule

// ===== design/packed_genotype_stream_decoder.sv =====
// Flow: a taken data byte is written into the queue, and its first result is
//   then loaded from the queue head into the output register.
// Throughput: one result per cycle from the back end while the output is not
//   stalled; a data byte yields 1 to 4 results.
// Reset: synchronous, active high; counters and queue clear, both config
//   registers return to 1, and the next three bytes are taken as header.
// ----------------------------------------------------------------------------
// Packed genotype stream decoder - top level
// SNP-major packed genotype byte stream to per-sample genotype results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_genotype_stream_decoder (
   input  logic                                    clock,
   input  logic                                    reset,
   // byte input
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  pgsd_pkg::req_payload_type               req_payload,
   // genotype results
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output pgsd_pkg::rsp_payload_type               rsp_payload,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pgsd_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [pgsd_pkg::CSR_DATA_W-1:0]         csr_data
);
   import pgsd_pkg::*;

   // Config registers. Writes never touch the decode counters.
   logic [20:0] sample_count_ff;
   logic [20:0] sample_count_in;
   logic [24:0] row_count_ff;
   logic [24:0] row_count_in;
   logic        csr_write;

   // front -> queue -> back
   logic            push;
   queue_entry_type push_entry;
   logic            pop;
   queue_entry_type head_entry;
   logic            head_valid;
   logic            queue_full;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      sample_count_in = sample_count_ff;
      row_count_in    = row_count_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_in = csr_data[20:0];
            CSR_ROW_COUNT:    row_count_in    = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= 21'd1;
         row_count_ff    <= 25'd1;
      end else begin
         sample_count_ff <= sample_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // Front end: header stripping. Start-of-file bytes become a clear entry so
   // the counter reset stays in order with queued data.
   pgsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Decouples byte intake from result emission; input stalls only when full.
   pgsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   // Back end: one 2-bit pair per cycle unless stalled; row wrap per sample.
   pgsd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .head_valid   (head_valid),
      .pop          (pop),
      .sample_count (sample_count_ff),
      .row_count    (row_count_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule

// ===== test/packed_genotype_stream_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed genotype stream decoder - testbench
// Feeds packed genotype files byte by byte and checks every decoded result
// against a cycle-free predictor of the row/sample counters. Directed bytes
// come first, then random files under random register settings. Both ends of
// the stream idle and stall at random.
// ----------------------------------------------------------------------------

module packed_genotype_stream_decoder_tb;

   import pgsd_pkg::*;

   localparam int MAX_REPORTS = 10;
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_DATA_BYTES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SAMPLE_COUNT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // bytes waiting to go in; the head leaves when the block takes it
   req_payload_type pending_bytes[$];
   // genotypes the block still owes us, oldest first
   rsp_payload_type expected_genotypes[$];

   // predictor copy of the block's state and registers
   logic [1:0]  hdr_seen = 2'd0;
   logic [19:0] sample_ctr = 20'd0;
   logic [23:0] row_ctr = 24'd0;
   logic [20:0] cfg_samples = 21'd1;
   logic [24:0] cfg_rows = 25'd1;

   int unsigned mismatch_count = 0;
   logic        byte_taken = 1'b0;
   bit          steady = 1'b0;   // no idling on either side while set
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;

   packed_genotype_stream_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Works out the genotypes one accepted byte yields and queues them.
   // Start of file restarts the header; the next two bytes are header too.
   // A data byte gives pairs LSB first until the row closes or the byte
   // runs out; pairs past the row end are padding.
   function automatic void decode_byte(input req_payload_type it);
      rsp_payload_type g;
      logic [20:0]     nxt;
      logic [1:0]      code;
      logic            row_done;
      if (it.start_of_file) begin
         sample_ctr = '0;
         row_ctr = '0;
         hdr_seen = 2'd1;
         return;
      end
      if (hdr_seen < HEADER_LEN) begin
         hdr_seen = hdr_seen + 2'd1;
         return;
      end
      for (int k = 0; k < 4; k++) begin
         code = it.data_byte[2*k +: 2];
         nxt = {1'b0, sample_ctr} + 21'd1;
         // a zero sample count closes every row at once; bit 20 set means
         // the 20-bit counter would overflow, which also closes the row
         row_done = (nxt >= cfg_samples) || nxt[20];
         g.row_index = row_ctr;
         g.sample_index = sample_ctr;
         // 2'b10 -> 1, 2'b11 -> 2, anything else (incl. missing) -> 0
         g.genotype = code[1] ? {code[0], ~code[0]} : 2'd0;
         g.out_of_range = ({1'b0, row_ctr} >= cfg_rows);
         g.last = row_done || (k == 3);
         expected_genotypes.push_back(g);
         if (row_done) begin
            sample_ctr = '0;
            if (row_ctr != ROW_MAX) row_ctr = row_ctr + 24'd1;
            break;
         end
         sample_ctr = nxt[19:0];
      end
   endfunction

   // Monitor: both handshakes are sampled here at the rising edge, so a
   // byte is predicted before any result it causes can be checked.
   always @(posedge clock) begin
      rsp_payload_type exp_g;
      if (reset) begin
         byte_taken <= 1'b0;
      end else begin
         byte_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            decode_byte(req_payload);
            void'(pending_bytes.pop_front());
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_genotypes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: unexpected result row %0d sample %0d geno %0d oor %0b last %0b",
                           $realtime, rsp_payload.row_index, rsp_payload.sample_index,
                           rsp_payload.genotype, rsp_payload.out_of_range,
                           rsp_payload.last);
            end else begin
               exp_g = expected_genotypes.pop_front();
               if (rsp_payload.row_index !== exp_g.row_index
                   || rsp_payload.sample_index !== exp_g.sample_index
                   || rsp_payload.genotype !== exp_g.genotype
                   || rsp_payload.out_of_range !== exp_g.out_of_range
                   || rsp_payload.last !== exp_g.last) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("%0t: mismatch expected row %0d sample %0d geno %0d oor %0b last %0b",
                              $realtime, exp_g.row_index, exp_g.sample_index,
                              exp_g.genotype, exp_g.out_of_range, exp_g.last);
                     $display("%0t:          got      row %0d sample %0d geno %0d oor %0b last %0b",
                              $realtime, rsp_payload.row_index, rsp_payload.sample_index,
                              rsp_payload.genotype, rsp_payload.out_of_range,
                              rsp_payload.last);
                  end
               end
            end
         end
      end
   end

   // Driver: presents the head of the byte queue on the falling edge and
   // holds it until taken, then idles for a random gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !byte_taken) begin
         // still waiting on the handshake, payload stays put
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (pending_bytes.size() > 0) begin
         req_valid <= 1'b1;
         req_payload <= pending_bytes[0];
         send_gap = pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap();
      end
   end

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SAMPLE_COUNT) cfg_samples = val[20:0];
      else cfg_rows = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] samples,
                            input logic [CSR_DATA_W-1:0] rows);
      write_register(CSR_SAMPLE_COUNT, samples);
      write_register(CSR_ROW_COUNT, rows);
   endtask

   task automatic push_byte(input logic [7:0] b, input logic sof);
      req_payload_type it;
      it.data_byte = b;
      it.start_of_file = sof;
      pending_bytes.push_back(it);
   endtask

   // Wait for every byte to be taken and every result to come back, then
   // give header bytes still in flight time to clear before any write.
   task automatic drain();
      while (pending_bytes.size() != 0 || expected_genotypes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_file(input int unsigned n_data);
      push_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat (2) push_byte(8'($urandom_range(0, 255)), 1'b0);
      repeat (n_data) push_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   initial begin : stimulus
      int data_left;
      int unsigned r;
      int unsigned n;
      logic [CSR_DATA_W-1:0] samples;
      logic [CSR_DATA_W-1:0] rows;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // After reset: three header bytes with no start flag, then one
      // sample per row with row count 1, so rows past the first are flagged.
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'hE4, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      drain();

      // Rows of three with padding; the write also carries junk above the
      // 21-bit sample count field.
      configure(25'h1E0_0003, 25'd2);
      push_byte(8'hAA, 1'b1);
      push_byte(8'h55, 1'b0);
      push_byte(8'hC3, 1'b0);
      push_byte(8'hE4, 1'b0);
      push_byte(8'h27, 1'b0);
      push_byte(8'hD8, 1'b0);
      drain();

      // Zero sample count acts as one, zero row count flags everything.
      configure(25'd0, 25'd0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h81, 1'b0);
      push_byte(8'h9C, 1'b0);
      push_byte(8'h63, 1'b0);
      drain();

      // Long row, then the sample count drops below the current sample:
      // the row has to close right after the next one.
      configure(25'd10, 25'h1FF_FFFF);
      push_byte(8'h3C, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      drain();
      configure(25'd2, 25'd1);
      push_byte(8'hE4, 1'b0);
      push_byte(8'hB1, 1'b0);
      drain();

      // Largest sample count settings.
      configure(25'h10_0000, 25'h100_0000);
      push_file(2);
      drain();
      configure(25'h1F_FFFF, 25'd1);
      push_file(1);

      // Random files. Mostly well-formed, some broken or pure noise.
      data_left = RANDOM_DATA_BYTES;
      while (data_left > 0) begin
         if ($urandom_range(0, 1) == 0) begin
            drain();
            r = $urandom_range(0, 9);
            if (r == 0) samples = 25'd0;
            else if (r == 1) samples = 25'($urandom_range(21'h10_0000, 21'h1F_FFFF));
            else samples = 25'($urandom_range(1, 12));
            r = $urandom_range(0, 9);
            if (r == 0) rows = 25'd0;
            else if (r == 1) rows = 25'($urandom_range(0, 25'h1FF_FFFF));
            else rows = 25'($urandom_range(1, 6));
            configure(samples, rows);
            steady = ($urandom_range(0, 3) == 0);
         end
         r = $urandom_range(0, 9);
         n = $urandom_range(1, 16);
         if (r < 7) begin
            push_file(n);
         end else if (r == 7) begin
            // header cut short
            push_byte(8'($urandom_range(0, 255)), 1'b1);
            repeat ($urandom_range(0, 1)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0);
         end else if (r == 8) begin
            // noise with stray start flags
            repeat (n) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end else begin
            // file carries on without a new start
            repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         data_left -= n;
      end

      drain();
      if (mismatch_count == 0)
         $display("packed_genotype_stream_decoder_tb passed");
      else
         $display("packed_genotype_stream_decoder_tb failed");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("packed_genotype_stream_decoder_tb failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/pgsd_pkg.sv
design/pgsd_front.sv
design/pgsd_queue.sv
design/pgsd_back.sv
design/packed_genotype_stream_decoder.sv
test/packed_genotype_stream_decoder_tb.sv
